[sv/prim_mst_dense_defines.svh]
// ----------------------------------------------------------------------------
// prim_mst_dense_defines.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef PRIM_MST_DENSE_DEFINES_SVH
`define PRIM_MST_DENSE_DEFINES_SVH

// condition holds, then the consequence holds in the next cycle
`define PMST_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pmst checker: next-cycle property failed");

// condition and consequence in the same cycle
`define PMST_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("pmst checker: same-cycle property failed");

`endif

[sv/pmst_pkg.sv]
// ----------------------------------------------------------------------------
// pmst_pkg
// shared constants and control struct of the dense-matrix spanning tree block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pmst_pkg;

    localparam int MAX_NODES  = 64;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int CNT_W      = NODE_W + 1;
    localparam int DIST_W     = 32;
    localparam int DADDR_W    = 2 * NODE_W;
    localparam int DDEPTH     = MAX_NODES * MAX_NODES;
    localparam int KEY_WORD_W = DIST_W + NODE_W;

    // input transaction kinds carried on tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(MAX_NODES);
    localparam logic [CNT_W-1:0] NODE_COUNT_MIN   = CNT_W'(2);

    // control from the sequencer to the relax unit
    typedef struct packed {
        logic              init;
        logic              valid;
        logic [NODE_W-1:0] v;
        logic              v_in_tree;
        logic              key_valid;
    } relax_ctl_t;

endpackage

[sv/pmst_ram.sv]
// ----------------------------------------------------------------------------
// pmst_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/pmst_relax.sv]
// ----------------------------------------------------------------------------
// pmst_relax
// key relaxation of one vertex per cycle and running minimum search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pmst_relax (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pmst_pkg::relax_ctl_t                ctl,
    input  logic [pmst_pkg::DIST_W-1:0]         row_dist,
    input  logic [pmst_pkg::KEY_WORD_W-1:0]     key_word,
    input  logic [pmst_pkg::NODE_W-1:0]         u,
    output logic                                key_we,
    output logic [pmst_pkg::KEY_WORD_W-1:0]     key_wdata,
    output logic [pmst_pkg::NODE_W-1:0]         sel
);

    logic [pmst_pkg::DIST_W-1:0] key_old;
    logic [pmst_pkg::DIST_W-1:0] key_new;
    logic                        take;

    logic [pmst_pkg::DIST_W-1:0] best_reg, best_next;
    logic [pmst_pkg::NODE_W-1:0] idx_reg, idx_next;
    logic [pmst_pkg::NODE_W-1:0] free_reg, free_next;
    logic                        found_reg, found_next;
    logic                        have_free_reg, have_free_next;

    // unwritten key entries read as infinity
    always_comb
    begin
        key_old   = ctl.key_valid ? key_word[pmst_pkg::KEY_WORD_W-1:pmst_pkg::NODE_W] : '1;
        take      = ctl.valid && (row_dist != '0) && !ctl.v_in_tree && (row_dist < key_old);
        key_new   = take ? row_dist : key_old;
        key_we    = take;
        key_wdata = {row_dist, u};
    end

    // lowest key among free vertices, first free vertex as fallback
    always_comb
    begin
        best_next      = best_reg;
        idx_next       = idx_reg;
        free_next      = free_reg;
        found_next     = found_reg;
        have_free_next = have_free_reg;
        if (ctl.init)
        begin
            best_next      = '1;
            idx_next       = '0;
            free_next      = '0;
            found_next     = 1'b0;
            have_free_next = 1'b0;
        end
        else if (ctl.valid && !ctl.v_in_tree)
        begin
            if (!have_free_reg)
            begin
                free_next      = ctl.v;
                have_free_next = 1'b1;
            end
            if (key_new < best_reg)
            begin
                best_next  = key_new;
                idx_next   = ctl.v;
                found_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= '1;
            idx_reg       <= '0;
            free_reg      <= '0;
            found_reg     <= 1'b0;
            have_free_reg <= 1'b0;
        end
        else
        begin
            best_reg      <= best_next;
            idx_reg       <= idx_next;
            free_reg      <= free_next;
            found_reg     <= found_next;
            have_free_reg <= have_free_next;
        end
    end

    assign sel = found_reg ? idx_reg : free_reg;

endmodule

[sv/prim_mst_dense.sv]
// ----------------------------------------------------------------------------
// prim_mst_dense
// dense distance matrix loader and prim spanning tree engine
// ----------------------------------------------------------------------------
// usage
//   s_* channel: tuser 0 loads one matrix entry (row, col, distance), tuser 1
//   starts a run from vertex 0 over the first node_count vertices.
//   m_* channel: one transaction per vertex 0 .. n-1 with vertex, parent and
//   the matrix distance to the parent; tlast marks vertex n-1.
//   cfg_we / cfg_wdata write node_count (clamped to 2 .. 64); the user must
//   write it only while idle, the block does not enforce this.
// loads and runs
//   loads may stream back to back. a run takes n-1 passes, each pass walking
//   one matrix row through the distance ram and the key ram (read, compare,
//   write back), then each result is read through the two ram read ports.
// reset
//   after reset a clearing pass writes zero to all 4096 matrix entries, one
//   per cycle; s_tready stays low until the clearing pass ends.
// stall
//   results sit in an output register; a stalled receiver holds the engine
//   before the next result, and after the last result new input is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prim_mst_dense (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // row[5:0], col[11:6], distance[43:12], zero pad
    input  logic        s_tuser,    // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // vertex[5:0], parent_vertex[11:6], edge_distance[43:12]
    output logic        m_tlast,    // last
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata   // node_count
);

    localparam int NW = pmst_pkg::NODE_W;
    localparam int CW = pmst_pkg::CNT_W;
    localparam int DW = pmst_pkg::DIST_W;
    localparam int AW = pmst_pkg::DADDR_W;
    localparam int KW = pmst_pkg::KEY_WORD_W;
    localparam int MN = pmst_pkg::MAX_NODES;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_RELAX  = 7'b0000100,
        ST_PICK   = 7'b0001000,
        ST_EMIT_A = 7'b0010000,
        ST_EMIT_B = 7'b0100000,
        ST_EMIT_C = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [CW-1:0]      iss_reg, iss_next;
    logic               stg_vld_reg, stg_vld_next;
    logic [NW-1:0]      stg_v_reg, stg_v_next;
    logic [NW-1:0]      u_reg, u_next;
    logic [CW-1:0]      round_reg, round_next;
    logic [NW-1:0]      i_reg, i_next;
    logic [NW-1:0]      p_reg, p_next;
    logic [MN-1:0]      in_tree_reg, in_tree_next;
    logic [MN-1:0]      kw_reg, kw_next;
    logic [CW-1:0]      node_count_reg, node_count_next;
    logic               m_valid_reg, m_valid_next;
    logic [47:0]        m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    logic [NW-1:0]      row;
    logic [NW-1:0]      col;
    logic [DW-1:0]      distance;
    logic               load_acc;
    logic               run_acc;
    logic [CW-1:0]      n;
    logic [CW-1:0]      n_last;
    logic [NW-1:0]      p_now;
    logic [NW-1:0]      emit_p;
    logic               out_free;

    logic               d_we;
    logic [AW-1:0]      d_waddr;
    logic [DW-1:0]      d_wdata;
    logic [AW-1:0]      d_raddr;
    logic [DW-1:0]      d_rdata;

    logic [NW-1:0]      k_raddr;
    logic [KW-1:0]      k_rdata;
    logic               k_we;
    logic [KW-1:0]      k_wdata;
    logic [NW-1:0]      sel;

    pmst_pkg::relax_ctl_t relax_ctl;

    // input fields
    assign row      = s_tdata[NW-1:0];
    assign col      = s_tdata[2*NW-1:NW];
    assign distance = s_tdata[2*NW+DW-1:2*NW];

    assign s_tready = (state_reg == ST_IDLE);
    assign load_acc = s_tvalid && s_tready && (s_tuser == pmst_pkg::OP_LOAD);
    assign run_acc  = s_tvalid && s_tready && (s_tuser == pmst_pkg::OP_RUN);

    // active vertex count, clamped
    always_comb
    begin
        priority if (node_count_reg < pmst_pkg::NODE_COUNT_MIN)
            n = pmst_pkg::NODE_COUNT_MIN;
        else if (node_count_reg > CW'(MN))
            n = CW'(MN);
        else
            n = node_count_reg;
    end
    assign n_last = n - CW'(1);

    // parent of the emitted vertex, unwritten entries mean parent 0
    assign p_now    = kw_reg[i_reg] ? k_rdata[NW-1:0] : '0;
    assign emit_p   = (state_reg == ST_EMIT_B) ? p_now : p_reg;
    assign out_free = !m_valid_reg || m_tready;

    // distance ram ports and key ram read address
    always_comb
    begin
        d_we    = (state_reg == ST_CLEAR) || load_acc;
        d_waddr = (state_reg == ST_CLEAR) ? clr_reg : {row, col};
        d_wdata = (state_reg == ST_CLEAR) ? '0 : distance;
        d_raddr = (state_reg == ST_RELAX) ? {u_reg, iss_reg[NW-1:0]} : {i_reg, emit_p};
        k_raddr = (state_reg == ST_RELAX) ? iss_reg[NW-1:0] : i_reg;
    end

    pmst_ram #(
        .WIDTH (DW),
        .DEPTH (pmst_pkg::DDEPTH)
    ) u_dist_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // key and parent ram
    pmst_ram #(
        .WIDTH (KW),
        .DEPTH (MN)
    ) u_key_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (stg_v_reg),
        .wdata (k_wdata),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    // relax unit control
    always_comb
    begin
        relax_ctl.init      = run_acc || (state_reg == ST_PICK);
        relax_ctl.valid     = stg_vld_reg;
        relax_ctl.v         = stg_v_reg;
        relax_ctl.v_in_tree = in_tree_reg[stg_v_reg];
        relax_ctl.key_valid = kw_reg[stg_v_reg];
    end

    pmst_relax u_relax (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (relax_ctl),
        .row_dist  (d_rdata),
        .key_word  (k_rdata),
        .u         (u_reg),
        .key_we    (k_we),
        .key_wdata (k_wdata),
        .sel       (sel)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        iss_next        = iss_reg;
        stg_vld_next    = 1'b0;
        stg_v_next      = stg_v_reg;
        u_next          = u_reg;
        round_next      = round_reg;
        i_next          = i_reg;
        p_next          = p_reg;
        in_tree_next    = in_tree_reg;
        kw_next         = kw_reg;
        node_count_next = cfg_we ? cfg_wdata : node_count_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;

        if (k_we)
        begin
            kw_next[stg_v_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (run_acc)
                begin
                    state_next   = ST_RELAX;
                    iss_next     = '0;
                    u_next       = '0;
                    round_next   = '0;
                    in_tree_next = MN'(1);
                    kw_next      = '0;
                end
            end
            ST_RELAX:
            begin
                if (iss_reg < n)
                begin
                    iss_next     = iss_reg + CW'(1);
                    stg_vld_next = 1'b1;
                    stg_v_next   = iss_reg[NW-1:0];
                end
                if (stg_vld_reg && ({1'b0, stg_v_reg} == n_last))
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                round_next = round_reg + CW'(1);
                u_next     = sel;
                in_tree_next[sel] = 1'b1;
                iss_next   = '0;
                if ((round_reg + CW'(1)) == n_last)
                begin
                    state_next = ST_EMIT_A;
                    i_next     = '0;
                end
                else
                begin
                    state_next = ST_RELAX;
                end
            end
            ST_EMIT_A:
            begin
                state_next = ST_EMIT_B;
            end
            ST_EMIT_B:
            begin
                p_next     = p_now;
                state_next = ST_EMIT_C;
            end
            ST_EMIT_C:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(48 - 2 * NW - DW){1'b0}}, d_rdata, p_reg, i_reg};
                    m_last_next  = ({1'b0, i_reg} == n_last);
                    if ({1'b0, i_reg} == n_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + NW'(1);
                        state_next = ST_EMIT_A;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            iss_reg        <= '0;
            stg_vld_reg    <= 1'b0;
            stg_v_reg      <= '0;
            u_reg          <= '0;
            round_reg      <= '0;
            i_reg          <= '0;
            in_tree_reg    <= '0;
            kw_reg         <= '0;
            node_count_reg <= pmst_pkg::NODE_COUNT_RESET;
            m_valid_reg    <= 1'b0;
            m_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            iss_reg        <= iss_next;
            stg_vld_reg    <= stg_vld_next;
            stg_v_reg      <= stg_v_next;
            u_reg          <= u_next;
            round_reg      <= round_next;
            i_reg          <= i_next;
            in_tree_reg    <= in_tree_next;
            kw_reg         <= kw_next;
            node_count_reg <= node_count_next;
            m_valid_reg    <= m_valid_next;
            m_last_reg     <= m_last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

[sv/pmst_checker.sv]
// ----------------------------------------------------------------------------
// pmst_checker
// port-level properties of the spanning tree block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "prim_mst_dense_defines.svh"

module pmst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds its payload
    `PMST_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a run transaction makes the block busy
    `PMST_ASSERT_NEXT(a_run_busy, s_tvalid && s_tready && s_tuser, !s_tready)

    // a load transaction leaves the input open
    `PMST_ASSERT_NEXT(a_load_open, s_tvalid && s_tready && !s_tuser, s_tready)

    // no result directly follows an accepted last one
    `PMST_ASSERT_NEXT(a_last_gap, m_tvalid && m_tready && m_tlast, !m_tvalid)

    // results only go out after the input has been closed by a run
    `PMST_ASSERT_SAME(a_out_not_idle_start, m_tvalid && !$past(m_tvalid) && rst_n, !s_tready || m_tlast)

endmodule

bind prim_mst_dense pmst_checker u_pmst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
